/* design/page_bitmap_allocator_assert.svh */
// Assertion macros for the page bitmap allocator.
// Define ASSERT_OFF to compile the checks out.
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// check on clk, idle during reset
`define PBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on clk, also during reset
`define PBA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PBA_ASSERT(label, prop, msg)
`define PBA_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* design/pba_pkg.sv */
package pba_pkg;

	// default sizes
	localparam int MAX_PAGES_DEF = 4096;
	localparam int MAX_ALLOC_DEF = 16;

	// free count saturates here
	localparam logic [12:0] COUNT_MAX = 13'h1FFF;

	// bitmap word width
	localparam int WORD_W = 32;

	// opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// register index (paddr[2])
	localparam logic REG_TOTAL   = 1'b0;
	localparam logic REG_PRESENT = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_SWAP   = 3'd1;
	localparam logic [2:0] ST_BAD_COUNT = 3'd2;
	localparam logic [2:0] ST_TOO_FEW   = 3'd3;
	localparam logic [2:0] ST_SKIPPED   = 3'd4;

	// lowest-free-bit search result
	typedef struct packed {
		logic        found;
		logic [4:0]  idx;
		logic [31:0] onehot;
	} pba_find_t;

endpackage

/* design/pba_ram.sv */
module pba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/pba_find_free.sv */
module pba_find_free (
	input  logic [31:0]       used,
	output pba_pkg::pba_find_t res
);
	import pba_pkg::*;

	logic [31:0] avail;
	logic [31:0] lowest;
	logic [4:0]  enc;

	// isolate lowest clear bit with a two's complement trick
	assign avail  = ~used;
	assign lowest = avail & (~avail + 32'd1);

	// one-hot to index
	always_comb begin
		enc = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (lowest[b]) begin
				enc = enc | 5'(b);
			end
		end
	end

	assign res.found  = |avail;
	assign res.idx    = enc;
	assign res.onehot = lowest;

endmodule

/* design/page_bitmap_allocator.sv */
// Page bitmap allocator: one used bit per swap page plus a free page count.
// Input channel (in_valid/in_ready) takes one word: opcode, request_count,
// free_index. Allocate asks for request_count pages; free releases one page.
// Output channel (out_valid/out_ready) returns page_number, last_of_run,
// status and free_count. A good allocate gives one word per page, lowest page
// first, last_of_run on the final one; anything else gives a single word.
// The bitmap sits in a RAM of 32-bit words. One priority encoder is shared by
// both allocate passes: pass one checks that enough pages are free, pass two
// marks them and emits them. In each pass a scanned word is read from the RAM,
// loaded into a register and then searched, its free pages picked one at a
// time. in_ready is high only between items.
// Reset, and any write of the page total, starts a clearing pass over the RAM,
// during which no word is accepted.
// Results go through an output register: a stalled receiver holds the block
// in its current step until the pending word is taken.
// Registers: page total at address 0, pagefile_present at address 4.
`include "page_bitmap_allocator_assert.svh"

module page_bitmap_allocator #(
	parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF,
	parameter int MAX_ALLOC = pba_pkg::MAX_ALLOC_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// config port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [7:0]                   request_count,
	input  logic [15:0]                  free_index,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [$clog2(MAX_PAGES)-1:0] page_number,
	output logic                         last_of_run,
	output logic [2:0]                   status,
	output logic [12:0]                  free_count
);
	import pba_pkg::*;

	localparam int WORDS   = MAX_PAGES / WORD_W;
	localparam int WADDR_W = WORDS > 1 ? $clog2(WORDS) : 1;
	localparam int PAGE_W  = $clog2(MAX_PAGES);
	localparam int ACT_W   = $clog2(MAX_PAGES + 1);
	localparam int GOT_W   = $clog2(MAX_ALLOC + 1);

	// sequencer states
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RES  = 3'd2;
	localparam logic [2:0] S_FWR  = 3'd3;
	localparam logic [2:0] S_LD   = 3'd4;
	localparam logic [2:0] S_PICK = 3'd5;

	logic [2:0]         state_q;
	logic [WADDR_W-1:0] w_q;
	logic [31:0]        word_q;
	logic [GOT_W-1:0]   got_q;
	logic [7:0]         want_q;
	logic               pass_q;
	logic [15:0]        idx_q;
	logic [2:0]         res_st_q;
	logic [12:0]        free_q;
	logic [12:0]        total_q;
	logic               present_q;

	logic               out_valid_q;
	logic [PAGE_W-1:0]  page_q;
	logic               last_q;
	logic [2:0]         status_q;
	logic [12:0]        fcnt_q;

	logic               ram_we;
	logic [WADDR_W-1:0] ram_waddr;
	logic [31:0]        ram_wdata;
	logic [WADDR_W-1:0] ram_raddr;
	logic [31:0]        ram_rdata;

	logic [ACT_W-1:0]   act;
	logic [ACT_W-1:0]   act_m1;
	logic [WADDR_W-1:0] lastw;
	logic [31:0]        beyond;
	logic [12:0]        free_inc;
	logic [12:0]        free_dec;
	logic               out_free;
	logic               in_acc;
	logic               cfg_wr;
	logic               pick_last;
	pba_find_t          find;

	// active page count of a page total value
	function automatic logic [ACT_W-1:0] act_of(input logic [12:0] t);
		act_of = (32'(t) > 32'(MAX_PAGES)) ? ACT_W'(MAX_PAGES) : ACT_W'(t);
	endfunction

	// free count loaded on a page total write
	function automatic logic [12:0] reload_of(input logic [ACT_W-1:0] a);
		reload_of = (32'(a) > 32'(COUNT_MAX)) ? COUNT_MAX : 13'(a);
	endfunction

	// bitmap storage
	pba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shared lowest-free-bit unit
	pba_find_free u_find (
		.used(word_q),
		.res (find)
	);

	// config access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_PRESENT) ? {31'd0, present_q} : {19'd0, total_q};

	// derived counts
	assign act      = act_of(total_q);
	assign act_m1   = ACT_W'(act - 1'b1);
	assign lastw    = WADDR_W'(act_m1 >> 5);
	assign free_inc = (free_q == COUNT_MAX) ? free_q : free_q + 13'd1;
	assign free_dec = (free_q >= 13'(want_q)) ? free_q - 13'(want_q) : 13'd0;

	// pages past the active count read as used
	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			beyond[b] = ((32'(w_q) << 5) + 32'(b)) >= 32'(act);
		end
	end

	// handshakes
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign pick_last = (8'(got_q) + 8'd1) == want_q;

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = word_q;
		ram_raddr = WADDR_W'(w_q + 1'b1);
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_raddr = (opcode == OP_FREE) ? WADDR_W'(free_index >> 5) : '0;
			end
			S_FWR: begin
				ram_we    = 1'b1;
				ram_waddr = WADDR_W'(idx_q >> 5);
				ram_wdata = ram_rdata & ~(32'd1 << idx_q[4:0]);
			end
			S_PICK: begin
				if (!pass_q) begin
					if (find.found && pick_last) begin
						ram_raddr = '0;
					end
				end else if (!find.found) begin
					ram_we = 1'b1;
				end else if (out_free && pick_last) begin
					ram_we    = 1'b1;
					ram_wdata = word_q | find.onehot;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			w_q       <= '0;
			got_q     <= '0;
			pass_q    <= 1'b0;
			res_st_q  <= ST_OK;
			free_q    <= '0;
			total_q   <= '0;
			present_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == REG_TOTAL) begin
			// new page total: reload the count and clear the map
			total_q <= pwdata[12:0];
			free_q  <= reload_of(act_of(pwdata[12:0]));
			w_q     <= '0;
			state_q <= S_CLR;
		end else begin
			case (state_q)
				S_CLR: begin
					if (w_q == WADDR_W'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						w_q <= WADDR_W'(w_q + 1'b1);
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						idx_q  <= free_index;
						want_q <= request_count;
						if (!present_q) begin
							res_st_q <= ST_NO_SWAP;
							state_q  <= S_RES;
						end else if (opcode == OP_FREE) begin
							if (32'(free_index) < 32'(act)) begin
								state_q <= S_FWR;
							end else begin
								res_st_q <= ST_SKIPPED;
								free_q   <= free_inc;
								state_q  <= S_RES;
							end
						end else if (request_count == 8'd0 ||
								request_count > 8'(MAX_ALLOC)) begin
							res_st_q <= ST_BAD_COUNT;
							state_q  <= S_RES;
						end else if (act == '0) begin
							res_st_q <= ST_TOO_FEW;
							state_q  <= S_RES;
						end else begin
							w_q     <= '0;
							got_q   <= '0;
							pass_q  <= 1'b0;
							state_q <= S_LD;
						end
					end
				end
				S_FWR: begin
					free_q   <= free_inc;
					res_st_q <= ST_OK;
					state_q  <= S_RES;
				end
				S_LD: begin
					word_q  <= ram_rdata | beyond;
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (!pass_q) begin
						// pass one: count free pages
						if (find.found) begin
							word_q <= word_q | find.onehot;
							if (pick_last) begin
								free_q  <= free_dec;
								w_q     <= '0;
								got_q   <= '0;
								pass_q  <= 1'b1;
								state_q <= S_LD;
							end else begin
								got_q <= GOT_W'(got_q + 1'b1);
							end
						end else if (w_q == lastw) begin
							res_st_q <= ST_TOO_FEW;
							state_q  <= S_RES;
						end else begin
							w_q     <= WADDR_W'(w_q + 1'b1);
							state_q <= S_LD;
						end
					end else begin
						// pass two: mark and emit
						if (find.found) begin
							if (out_free) begin
								word_q <= word_q | find.onehot;
								got_q  <= GOT_W'(got_q + 1'b1);
								if (pick_last) begin
									state_q <= S_IDLE;
								end
							end
						end else begin
							w_q     <= WADDR_W'(w_q + 1'b1);
							state_q <= S_LD;
						end
					end
				end
				S_RES: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// register writes
			if (cfg_wr) begin
				present_q <= pwdata[0];
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_RES && out_free) ||
				(state_q == S_PICK && pass_q && find.found && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_RES && out_free) begin
			page_q   <= '0;
			last_q   <= 1'b1;
			status_q <= res_st_q;
			fcnt_q   <= free_q;
		end else if (state_q == S_PICK && pass_q && find.found && out_free) begin
			page_q   <= PAGE_W'({w_q, find.idx});
			last_q   <= pick_last;
			status_q <= ST_OK;
			fcnt_q   <= free_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign page_number = page_q;
	assign last_of_run = last_q;
	assign status      = status_q;
	assign free_count  = fcnt_q;

	// checks
	`PBA_ASSERT(a_got_bound, (state_q == S_PICK) |-> (8'(got_q) < want_q), "pick count overran request")
	`PBA_ASSERT(a_pass2_range, (state_q == S_PICK && pass_q) |-> (w_q <= lastw), "second pass ran past the active pages")
	`PBA_ASSERT(a_fail_single, (out_valid && status != ST_OK) |-> last_of_run, "failure word not marked last")
	`PBA_ASSERT(a_cfg_clear, (cfg_wr && paddr[2] == REG_TOTAL) |=> (state_q == S_CLR), "page total write did not start clearing")
	`PBA_ASSERT_ALWAYS(a_rst_ready, !arst_n |-> !in_ready, "ready during reset")

endmodule
